/* rtl/core/arpc_pkg.sv */
package arpc_pkg;

  localparam int unsigned IpW    = 32;
  localparam int unsigned MacW   = 48;
  localparam int unsigned IfW    = 4;
  localparam int unsigned CntW   = 8;
  localparam int unsigned KindW  = 4;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned RetryW = 3;
  localparam int unsigned ToW    = 16;
  localparam int unsigned IvW    = 8;

  // replacement slot is the lfsr value masked to the slot bits, so this stays a power of two
  localparam int unsigned CacheEntries = 32;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_APPEND = 2'd2,
    REQ_TICK   = 2'd3
  } req_e;

  typedef enum logic [KindW-1:0] {
    RES_MISS    = 4'd0,
    RES_HIT     = 4'd1,
    RES_REQUEST = 4'd2,
    RES_APPEND  = 4'd3,
    RES_FULL    = 4'd4,
    RES_RELEASE = 4'd5,
    RES_RETX    = 4'd6,
    RES_UNREACH = 4'd7,
    RES_DONE    = 4'd8
  } res_e;

  typedef enum logic [1:0] {
    CFG_TIMEOUT  = 2'd0,
    CFG_RETRIES  = 2'd1,
    CFG_INTERVAL = 2'd2
  } cfg_e;

  localparam logic [15:0] LfsrSeed = 16'hACE1;
  localparam logic [15:0] LfsrTaps = 16'hB400;

  typedef struct packed {
    res_e             kind;
    logic [MacW-1:0]  mac;
    logic [IpW-1:0]   ip;
    logic [IfW-1:0]   iface;
    logic [CntW-1:0]  count;
    logic             last;
  } result_t;

endpackage

/* rtl/core/arpc_ram.sv */
module arpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/core/arp_cache_with_pending_retry.sv */
// channel  | dir | handshake             | payload
// s_axis   | in  | tvalid/tready         | tuser: req_type; tdata: ip_addr, mac_addr, iface_id
// m_axis   | out | tvalid/tready, tlast  | tuser: result_kind; tdata: out_mac, out_ip,
//          |     |                       |        out_iface, packet_count; tlast = last
// cfg      | in  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
// an item scans the cache slots and then the pending slots (an append scans only the
// pending table, a lookup only the cache), each slot read in S_CRD or S_PRD and checked in
// S_CCHK or S_PCHK, one entry at a time from the cache and pending memories; the longest
// item is an insert into a full cache, an insert stops its cache scan at the first free
// slot, and a lookup hit or an append that finds its entry ends early.
// reset clears the valid bits, time and lfsr at once; the memories need no clearing.
// a result waits in the output register; the next item may start meanwhile, but while that
// register is full its cache scan stalls on a hit and each pending check and S_FIN wait.
module arp_cache_with_pending_retry
  import arpc_pkg::*;
#(
  parameter int unsigned PENDING_ENTRIES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // req_type[1:0]
  input  logic [1:0]   s_axis_tuser,
  // ip_addr[31:0], mac_addr[79:32], iface_id[83:80], zero pad
  input  logic [87:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_kind[3:0]
  output logic [3:0]   m_axis_tuser,
  // out_mac[47:0], out_ip[79:48], out_iface[83:80], packet_count[91:84], zero pad
  output logic [95:0]  m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);

  localparam int unsigned CW = (CacheEntries > 1) ? $clog2(CacheEntries) : 1;
  localparam int unsigned PW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
  localparam int unsigned CacheDw = IpW + MacW + TimeW;
  localparam int unsigned PendDw  = IpW + IfW + CntW + TimeW + RetryW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CRD   = 4'd1;
  localparam logic [3:0] S_CCHK  = 4'd2;
  localparam logic [3:0] S_CWR   = 4'd3;
  localparam logic [3:0] S_PRD   = 4'd4;
  localparam logic [3:0] S_PCHK  = 4'd5;
  localparam logic [3:0] S_OUT   = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;

  logic [3:0] state_q, state_d;
  req_e       op_q;
  logic [IpW-1:0]  ip_q;
  logic [MacW-1:0] mac_q;
  logic [IfW-1:0]  if_q;

  logic [ToW-1:0]    timeout_q;
  logic [RetryW-1:0] maxret_q;
  logic [IvW-1:0]    interval_q;
  logic [TimeW-1:0]  now_q;
  logic [15:0]       lfsr_q;

  logic [CacheEntries-1:0]    cvalid_q;
  logic [PENDING_ENTRIES-1:0] pvalid_q;

  logic [CW-1:0] cidx_q;
  logic [PW-1:0] pidx_q;
  logic [PW-1:0] pfree_q;
  logic          pfree_ok_q;
  logic          done_q;       // cleared per item and never set

  result_t out_q;
  logic    out_valid_q;
  logic    pend_after_q;         // in S_OUT: go to S_PRD (1) or idle (0)

  // memories
  logic              c_we;
  logic [CW-1:0]     c_addr;
  logic [CacheDw-1:0] c_wdata, c_rdata;
  logic              p_we;
  logic [PW-1:0]     p_waddr;
  logic [PendDw-1:0] p_wdata, p_rdata;

  arpc_ram #(.Width(CacheDw), .Depth(CacheEntries)) u_cache (
    .clk_i, .we_i(c_we), .waddr_i(c_addr), .wdata_i(c_wdata),
    .raddr_i(c_addr), .rdata_o(c_rdata)
  );
  arpc_ram #(.Width(PendDw), .Depth(PENDING_ENTRIES)) u_pend (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(pidx_q), .rdata_o(p_rdata)
  );

  logic [IpW-1:0]    cr_ip;
  logic [TimeW-1:0]  cr_added;
  logic [IpW-1:0]    pr_ip;
  logic [IfW-1:0]    pr_if;
  logic [CntW-1:0]   pr_cnt;
  logic [TimeW-1:0]  pr_sent;
  logic [RetryW-1:0] pr_ret;
  assign cr_ip    = c_rdata[CacheDw-1 -: IpW];
  assign cr_added = c_rdata[TimeW-1:0];
  assign {pr_ip, pr_if, pr_cnt, pr_sent, pr_ret} = p_rdata;

  logic [CW-1:0] cslot;
  assign cslot = cidx_q;
  logic [PW-1:0] pslot;
  assign pslot = pidx_q;

  // first free cache slot, found while scanning; replacement from lfsr otherwise
  logic [CW-1:0] cfree_q;
  logic          cfree_ok_q;
  logic [15:0]   lfsr_next;
  assign lfsr_next = lfsr_q[0] ? ((lfsr_q >> 1) ^ LfsrTaps) : (lfsr_q >> 1);

  logic [TimeW-1:0] c_age, p_age;
  assign c_age = now_q - cr_added;
  assign p_age = now_q - pr_sent;

  logic ow_free;
  assign ow_free = !out_valid_q || m_axis_tready;

  logic c_hit;
  assign c_hit = (op_q == REQ_LOOKUP) && cvalid_q[cslot] && (cr_ip == ip_q);

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {4'b0000, out_q.count, out_q.iface, out_q.ip, out_q.mac};

  result_t res_d;
  logic    emit;
  logic [CW-1:0] ins_slot;

  always_comb begin
    ins_slot = cfree_ok_q ? cfree_q : lfsr_next[CW-1:0];
    state_d = state_q;
    emit = 1'b0;
    res_d = '{kind: RES_DONE, mac: '0, ip: '0, iface: '0, count: '0, last: 1'b1};
    c_we = 1'b0;
    c_addr = cslot;
    c_wdata = {ip_q, mac_q, now_q};
    p_we = 1'b0;
    p_waddr = pslot;
    p_wdata = p_rdata;
    if (state_q == S_CWR) c_addr = ins_slot;
    if (state_q == S_FIN && op_q == REQ_APPEND && !done_q) begin
      p_waddr = pfree_q;
      p_wdata = {ip_q, if_q, CntW'(1), now_q, RetryW'(0)};
    end
    unique case (state_q)
      S_CCHK: begin
        if (c_hit && ow_free) begin
          emit = 1'b1;
          res_d = '{kind: RES_HIT, mac: c_rdata[TimeW +: MacW], ip: ip_q,
                    iface: '0, count: '0, last: 1'b1};
        end
      end
      S_PCHK: begin
        if (pvalid_q[pslot] && ow_free) begin
          unique case (op_q)
            REQ_INSERT: begin
              if (pr_ip == ip_q) begin
                emit = 1'b1;
                res_d = '{kind: RES_RELEASE, mac: mac_q, ip: ip_q, iface: pr_if,
                          count: pr_cnt, last: 1'b0};
              end
            end
            REQ_APPEND: begin
              if (pr_ip == ip_q && pr_if == if_q) begin
                emit = 1'b1;
                p_we = 1'b1;
                p_wdata = {pr_ip, pr_if, (pr_cnt == 8'hFF) ? pr_cnt : pr_cnt + 8'd1,
                           pr_sent, pr_ret};
                res_d = '{kind: RES_APPEND, mac: '0, ip: ip_q, iface: if_q,
                          count: (pr_cnt == 8'hFF) ? pr_cnt : pr_cnt + 8'd1, last: 1'b1};
              end
            end
            REQ_TICK: begin
              if (p_age >= TimeW'(interval_q)) begin
                emit = 1'b1;
                res_d = '{kind: (pr_ret >= maxret_q) ? RES_UNREACH : RES_RETX, mac: '0,
                          ip: pr_ip, iface: pr_if, count: pr_cnt, last: 1'b0};
                if (pr_ret < maxret_q) begin
                  p_we = 1'b1;
                  p_wdata = {pr_ip, pr_if, pr_cnt, now_q, pr_ret + RetryW'(1)};
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_FIN: begin
        emit = ow_free;
        unique case (op_q)
          REQ_LOOKUP: res_d = '{kind: RES_MISS, mac: '0, ip: ip_q, iface: '0,
                                count: '0, last: 1'b1};
          REQ_APPEND: begin
            if (pfree_ok_q) begin
              p_we = ow_free;
              res_d = '{kind: RES_REQUEST, mac: '0, ip: ip_q, iface: if_q,
                        count: CntW'(1), last: 1'b1};
            end else begin
              res_d = '{kind: RES_FULL, mac: '0, ip: ip_q, iface: if_q,
                        count: '0, last: 1'b1};
            end
          end
          default: ;
        endcase
      end
      S_CWR: c_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      timeout_q <= ToW'(15);
      maxret_q <= RetryW'(5);
      interval_q <= IvW'(1);
      now_q <= '0;
      lfsr_q <= LfsrSeed;
      cvalid_q <= '0;
      pvalid_q <= '0;
      out_valid_q <= 1'b0;
      cidx_q <= '0;
      pidx_q <= '0;
      pfree_q <= '0;
      pfree_ok_q <= 1'b0;
      cfree_q <= '0;
      cfree_ok_q <= 1'b0;
      done_q <= 1'b0;
      pend_after_q <= 1'b0;
      op_q <= REQ_LOOKUP;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_TIMEOUT:  timeout_q <= cfg_data_i[ToW-1:0];
          CFG_RETRIES:  maxret_q <= cfg_data_i[RetryW-1:0];
          CFG_INTERVAL: interval_q <= cfg_data_i[IvW-1:0];
          default: ;
        endcase
      end
      if (emit) begin
        out_q <= res_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            op_q <= req_e'(s_axis_tuser);
            ip_q <= s_axis_tdata[31:0];
            mac_q <= s_axis_tdata[79:32];
            if_q <= s_axis_tdata[83:80];
            cidx_q <= '0;
            pidx_q <= '0;
            cfree_ok_q <= 1'b0;
            pfree_ok_q <= 1'b0;
            done_q <= 1'b0;
            if (s_axis_tuser == REQ_APPEND) state_q <= S_PRD;
            else begin
              state_q <= S_CRD;
              if (s_axis_tuser == REQ_TICK) now_q <= now_q + TimeW'(1);
            end
          end
        end
        S_CRD: state_q <= S_CCHK;
        S_CCHK: begin
          if (op_q == REQ_TICK && cvalid_q[cslot] && c_age > TimeW'(timeout_q))
            cvalid_q[cslot] <= 1'b0;
          if (!cvalid_q[cslot] && !cfree_ok_q) begin
            cfree_ok_q <= 1'b1;
            cfree_q <= cslot;
          end
          if (c_hit) begin
            pend_after_q <= 1'b0;
            if (ow_free) state_q <= S_OUT;
          end else if (cidx_q == CW'(CacheEntries - 1)
                       || (op_q == REQ_INSERT && !cvalid_q[cslot])) begin
            unique case (op_q)
              REQ_LOOKUP: state_q <= S_FIN;
              REQ_INSERT: state_q <= S_CWR;
              default:    state_q <= S_PRD;
            endcase
          end else begin
            cidx_q <= cidx_q + CW'(1);
            state_q <= S_CRD;
          end
        end
        S_CWR: begin
          if (!cfree_ok_q) lfsr_q <= lfsr_next;
          cvalid_q[ins_slot] <= 1'b1;
          state_q <= S_PRD;
        end
        S_PRD: state_q <= S_PCHK;
        S_PCHK: begin
          if (ow_free) begin
            if (!pvalid_q[pslot] && !pfree_ok_q) begin
              pfree_ok_q <= 1'b1;
              pfree_q <= pidx_q;
            end
            if (emit) begin
              if (op_q == REQ_INSERT
                  || (op_q == REQ_TICK && res_d.kind == RES_UNREACH))
                pvalid_q[pslot] <= 1'b0;
            end
            if (emit && op_q == REQ_APPEND) begin
              state_q <= S_IDLE;
            end else if (pidx_q == PW'(PENDING_ENTRIES - 1)) begin
              state_q <= S_FIN;
            end else begin
              pidx_q <= pidx_q + PW'(1);
              state_q <= S_PRD;
            end
          end
        end
        S_FIN: begin
          if (ow_free) begin
            if (op_q == REQ_APPEND && pfree_ok_q) pvalid_q[pfree_q] <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_OUT: state_q <= pend_after_q ? S_PRD : S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
